// ===== sv/hpsd_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, types, register indexes, reset values and saturation helpers
// for the passivity spring-damper block. No dependencies.

package hpsd_pkg;

   localparam int FRAC_BITS = 16;
   localparam int DATA_W    = 32;
   localparam int GAIN_W    = 31;
   localparam int ENERGY_W  = 48;
   localparam int CSR_IDX_W = 3;

   localparam int VSQ_W     = 2 * DATA_W - 1;
   localparam int PSQ_W     = VSQ_W - FRAC_BITS;
   localparam int MUL_A_W   = PSQ_W + 1;
   localparam int MUL_B_W   = DATA_W + 1;
   localparam int PROD_W    = MUL_A_W + MUL_B_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int MUL_CNT_W = $clog2(MUL_B_W);

   localparam int REM_W     = VSQ_W + 1;
   localparam int DIV_N_W   = ENERGY_W + 2 * FRAC_BITS;
   localparam int DIV_R0_W  = DIV_N_W - GAIN_W;
   localparam int DIV_CMP_W = (DIV_R0_W > REM_W) ? DIV_R0_W : REM_W;
   localparam int DIV_CNT_W = $clog2(GAIN_W);

   typedef logic signed [DATA_W-1:0]   data_type;
   typedef logic        [GAIN_W-1:0]   gain_type;
   typedef logic signed [ENERGY_W-1:0] energy_type;
   typedef logic signed [MUL_A_W-1:0]  mul_a_type;
   typedef logic signed [MUL_B_W-1:0]  mul_b_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [SUM_W-1:0]    sum_type;
   typedef logic        [VSQ_W-1:0]    vsq_type;
   typedef logic        [PSQ_W-1:0]    psq_type;

   localparam logic [CSR_IDX_W-1:0] CSR_SPRING_STIFFNESS = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DAMPING_COEFF    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FORCE_THRESHOLD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_JOINT_STIFFNESS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TORQUE_LIMIT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MODE       = 3'd5;

   localparam gain_type GAIN_MAX = '1;

   localparam sum_type S32_MAX = {{(SUM_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
   localparam sum_type S32_MIN = ~S32_MAX;
   localparam sum_type E_MAX   = {{(SUM_W - ENERGY_W + 1){1'b0}}, {(ENERGY_W - 1){1'b1}}};
   localparam sum_type E_MIN   = ~E_MAX;

   localparam longint   ONE_Q       = longint'(1) << FRAC_BITS;
   localparam data_type SPRING_RST  = data_type'((ONE_Q + 5) / 10);
   localparam data_type DAMP_RST    = data_type'(-((ONE_Q * 2 + 500) / 1000));
   localparam data_type THRESH_RST  = '0;
   localparam gain_type JSTIFF_RST  = gain_type'(longint'(12000) << FRAC_BITS);
   localparam gain_type TLIMIT_RST  = gain_type'(longint'(400) << FRAC_BITS);
   localparam logic     MODE_RST    = 1'b1;

   // Fixed-point rescale of a product, rounding toward minus infinity.
   function automatic sum_type frac_shift(input prod_type x);
      sum_type w;
      w = {x[PROD_W-1], x};
      return w >>> FRAC_BITS;
   endfunction

   function automatic data_type sat32(input sum_type x);
      sum_type y;
      y = x;
      if (x > S32_MAX) begin
         y = S32_MAX;
      end else if (x < S32_MIN) begin
         y = S32_MIN;
      end
      return y[DATA_W-1:0];
   endfunction

   function automatic energy_type sat48(input sum_type x);
      sum_type y;
      y = x;
      if (x > E_MAX) begin
         y = E_MAX;
      end else if (x < E_MIN) begin
         y = E_MIN;
      end
      return y[ENERGY_W-1:0];
   endfunction

endpackage

// ===== sv/hpsd_mul.sv =====
`timescale 1ns / 1ps
// Serial signed multiplier: one multiplier bit per cycle, right-shifting
// partial product. Depends on hpsd_pkg.

module hpsd_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  hpsd_pkg::mul_a_type a,
   input  hpsd_pkg::mul_b_type b,
   output logic               busy,
   output hpsd_pkg::prod_type  product
);
   import hpsd_pkg::*;

   localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_B_W - 1);

   logic signed [MUL_A_W:0]       a_ff, a_in;
   logic signed [MUL_A_W:0]       hi_ff, hi_in;
   logic signed [MUL_A_W:0]       addend, total;
   logic [MUL_B_W-1:0]            lo_ff, lo_in;
   logic [MUL_CNT_W-1:0]          cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic [MUL_A_W+MUL_B_W:0]      full;

   always_comb begin
      addend = '0;
      if (lo_ff[0]) begin
         if (cnt_ff == MUL_LAST) begin
            addend = -a_ff;
         end else begin
            addend = a_ff;
         end
      end
      total = hi_ff + addend;

      a_in    = a_ff;
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         a_in    = {a[MUL_A_W-1], a};
         hi_in   = '0;
         lo_in   = b;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         hi_in  = {total[MUL_A_W], total[MUL_A_W:1]};
         lo_in  = {total[0], lo_ff[MUL_B_W-1:1]};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == MUL_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      cnt_ff <= cnt_in;
   end

   assign full    = {hi_ff, lo_ff};
   assign product = full[PROD_W-1:0];
   assign busy    = busy_ff;

endmodule

// ===== sv/hpsd_div.sv =====
`timescale 1ns / 1ps
// Serial restoring divider for the damping gain: one quotient bit per cycle,
// saturating at the gain maximum. Depends on hpsd_pkg.

module hpsd_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [hpsd_pkg::ENERGY_W-1:0] num,
   input  hpsd_pkg::vsq_type             den,
   output logic                          busy,
   output hpsd_pkg::gain_type            quotient
);
   import hpsd_pkg::*;

   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(GAIN_W - 1);

   logic [DIV_N_W-1:0]   dividend;
   logic [DIV_CMP_W-1:0] head, den_wide;
   logic [REM_W-1:0]     rem_ff, rem_in, trial, den_ext;
   logic [GAIN_W-1:0]    low_ff, low_in;
   gain_type             quo_ff, quo_in;
   vsq_type              den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;

   always_comb begin
      dividend = {num, {(2 * FRAC_BITS){1'b0}}};
      head     = DIV_CMP_W'(dividend[DIV_N_W-1:GAIN_W]);
      den_wide = DIV_CMP_W'(den);
      den_ext  = {1'b0, den_ff};
      trial    = {rem_ff[REM_W-2:0], low_ff[GAIN_W-1]};

      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         // A leading partial remainder at or above the divisor means the
         // quotient cannot fit, which also covers a zero divisor.
         if (head >= den_wide) begin
            quo_in = GAIN_MAX;
         end else begin
            rem_in  = head[REM_W-1:0];
            low_in  = dividend[GAIN_W-1:0];
            den_in  = den;
            quo_in  = '0;
            cnt_in  = '0;
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (trial >= den_ext) begin
            rem_in = trial - den_ext;
            quo_in = {quo_ff[GAIN_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[GAIN_W-2:0], 1'b0};
         end
         low_in = {low_ff[GAIN_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

// ===== sv/haptic_passivity_spring_damper.sv =====
`timescale 1ns / 1ps
// Passivity-controlled spring-damper force and joint spring torque, one request per tick.
// The block takes no new request until the last one is through (req_stall is high while busy):
// four passes through the bit-serial multipliers (the gain divider runs alongside the third
// pass), then the result is loaded into the response registers, which rsp_stall can hold off.
// Synchronous reset restores the register defaults and clears the observer state.

module haptic_passivity_spring_damper (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_wr_en,
   input  logic [hpsd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [hpsd_pkg::DATA_W-1:0]    csr_wr_data,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  hpsd_pkg::data_type             req_position_x,
   input  hpsd_pkg::data_type             req_velocity_x,
   input  hpsd_pkg::data_type             req_joint_angle,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output hpsd_pkg::data_type             rsp_drive_value,
   output logic                           rsp_drive_is_torque,
   output hpsd_pkg::gain_type             rsp_damping_gain,
   output hpsd_pkg::energy_type           rsp_energy_sum
);
   import hpsd_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PH1  = 3'd1;
   localparam logic [2:0] ST_PH2  = 3'd2;
   localparam logic [2:0] ST_PH3  = 3'd3;
   localparam logic [2:0] ST_PH4  = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   data_type   ss_ff, ss_in, dc_ff, dc_in, thr_ff, thr_in;
   gain_type   js_ff, js_in, lim_ff, lim_in;
   logic       mode_ff, mode_in;

   logic [2:0] state_ff, state_in;
   logic       go_ff, go_in;

   logic       started_ff, started_in;
   energy_type obs_ff, obs_in;
   gain_type   pgain_ff, pgain_in;
   data_type   pvel_ff, pvel_in;

   data_type   pos_ff, pos_in, vel_ff, vel_in, ang_ff, ang_in;
   data_type   force_ff, force_in;
   psq_type    psq_ff, psq_in;
   energy_type energy_ff, energy_in;
   vsq_type    vsq_ff, vsq_in;
   gain_type   alpha_ff, alpha_in, torque_ff, torque_in;

   logic       rsp_valid_ff, rsp_valid_in;
   data_type   rsp_drive_ff, rsp_drive_in;
   logic       rsp_torque_ff, rsp_torque_in;
   gain_type   rsp_gain_ff, rsp_gain_in;
   energy_type rsp_energy_ff, rsp_energy_in;

   mul_a_type  a0, a1, a2;
   mul_b_type  b0, b1, b2;
   logic       st0, st1, st2, div_start;
   logic       busy0, busy1, busy2, div_busy;
   prod_type   p0, p1, p2, p0_neg;
   gain_type   div_q;
   logic [ENERGY_W-1:0] div_num;

   mul_a_type  vel_a, ss_a, force_a, pv_a, psq_a, js_a;
   mul_b_type  vel_b, dc_b, ndc_b, pos_b, toward_b, thr_b, ang_b, nang_b;
   mul_b_type  pv_b, pgain_b, alpha_b;
   logic       active, phase_end;

   sum_type    fsum, power, tsh, term, obs_ext, esum, tq, lim_ext, adj, fext;
   data_type   force_p1, force_p4;
   energy_type energy_p2;
   gain_type   torque_p3, alpha_p3;

   always_comb begin
      vel_a    = {{(MUL_A_W - DATA_W){vel_ff[DATA_W-1]}}, vel_ff};
      ss_a     = {{(MUL_A_W - DATA_W){ss_ff[DATA_W-1]}}, ss_ff};
      force_a  = {{(MUL_A_W - DATA_W){force_ff[DATA_W-1]}}, force_ff};
      pv_a     = {{(MUL_A_W - DATA_W){pvel_ff[DATA_W-1]}}, pvel_ff};
      psq_a    = {{(MUL_A_W - PSQ_W){1'b0}}, psq_ff};
      js_a     = {{(MUL_A_W - GAIN_W){1'b0}}, js_ff};
      vel_b    = {vel_ff[DATA_W-1], vel_ff};
      dc_b     = {dc_ff[DATA_W-1], dc_ff};
      ndc_b    = -dc_b;
      pos_b    = {pos_ff[DATA_W-1], pos_ff};
      toward_b = -pos_b;
      thr_b    = {thr_ff[DATA_W-1], thr_ff};
      ang_b    = {ang_ff[DATA_W-1], ang_ff};
      nang_b   = -ang_b;
      pv_b     = {pvel_ff[DATA_W-1], pvel_ff};
      pgain_b  = {{(MUL_B_W - GAIN_W){1'b0}}, pgain_ff};
      alpha_b  = {{(MUL_B_W - GAIN_W){1'b0}}, alpha_ff};
      active   = toward_b < thr_b;
   end

   always_comb begin
      a0 = vel_a;
      b0 = ndc_b;
      a1 = ss_a;
      b1 = toward_b;
      a2 = pv_a;
      b2 = pv_b;
      case (state_ff)
         ST_PH2: begin
            a0 = force_a;
            b0 = vel_b;
            a1 = psq_a;
            b1 = pgain_b;
            a2 = vel_a;
            b2 = vel_b;
         end
         ST_PH3: begin
            a2 = js_a;
            b2 = nang_b;
         end
         ST_PH4: begin
            a0 = vel_a;
            b0 = alpha_b;
         end
         default: ;
      endcase
   end

   assign st0       = go_ff && (state_ff inside {ST_PH1, ST_PH2, ST_PH4});
   assign st1       = go_ff && (state_ff inside {ST_PH1, ST_PH2});
   assign st2       = go_ff && (state_ff inside {ST_PH1, ST_PH2, ST_PH3});
   assign div_start = go_ff && (state_ff == ST_PH3);
   assign div_num   = -energy_ff;
   assign phase_end = !go_ff && !busy0 && !busy1 && !busy2 && !div_busy;

   hpsd_mul u_mul0 (
      .clock   (clock),
      .reset   (reset),
      .start   (st0),
      .a       (a0),
      .b       (b0),
      .busy    (busy0),
      .product (p0)
   );

   hpsd_mul u_mul1 (
      .clock   (clock),
      .reset   (reset),
      .start   (st1),
      .a       (a1),
      .b       (b1),
      .busy    (busy1),
      .product (p1)
   );

   hpsd_mul u_mul2 (
      .clock   (clock),
      .reset   (reset),
      .start   (st2),
      .a       (a2),
      .b       (b2),
      .busy    (busy2),
      .product (p2)
   );

   hpsd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (div_num),
      .den      (vsq_ff),
      .busy     (div_busy),
      .quotient (div_q)
   );

   always_comb begin
      fsum     = frac_shift(p0) + frac_shift(p1);
      force_p1 = active ? sat32(fsum) : '0;

      p0_neg    = -p0;
      power     = frac_shift(p0_neg);
      tsh       = frac_shift(p1);
      term      = (tsh > E_MAX) ? E_MAX : tsh;
      obs_ext   = {{(SUM_W - ENERGY_W){obs_ff[ENERGY_W-1]}}, obs_ff};
      esum      = started_ff ? (obs_ext + power + term) : power;
      energy_p2 = sat48(esum);

      tq        = frac_shift(p2);
      lim_ext   = {{(SUM_W - GAIN_W){1'b0}}, lim_ff};
      torque_p3 = '0;
      if (ang_ff[DATA_W-1]) begin
         torque_p3 = (tq > lim_ext) ? lim_ff : tq[GAIN_W-1:0];
      end
      alpha_p3  = (started_ff && energy_ff[ENERGY_W-1]) ? div_q : '0;

      adj      = frac_shift(p0);
      fext     = {{(SUM_W - DATA_W){force_ff[DATA_W-1]}}, force_ff};
      force_p4 = active ? sat32(fext - adj) : force_ff;
   end

   always_comb begin
      ss_in   = ss_ff;
      dc_in   = dc_ff;
      thr_in  = thr_ff;
      js_in   = js_ff;
      lim_in  = lim_ff;
      mode_in = mode_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_SPRING_STIFFNESS: ss_in   = csr_wr_data;
            CSR_DAMPING_COEFF:    dc_in   = csr_wr_data;
            CSR_FORCE_THRESHOLD:  thr_in  = csr_wr_data;
            CSR_JOINT_STIFFNESS:  js_in   = csr_wr_data[GAIN_W-1:0];
            CSR_TORQUE_LIMIT:     lim_in  = csr_wr_data[GAIN_W-1:0];
            CSR_DRIVE_MODE:       mode_in = csr_wr_data[0];
            default: ;
         endcase
      end

      state_in      = state_ff;
      go_in         = 1'b0;
      started_in    = started_ff;
      obs_in        = obs_ff;
      pgain_in      = pgain_ff;
      pvel_in       = pvel_ff;
      pos_in        = pos_ff;
      vel_in        = vel_ff;
      ang_in        = ang_ff;
      force_in      = force_ff;
      psq_in        = psq_ff;
      energy_in     = energy_ff;
      vsq_in        = vsq_ff;
      alpha_in      = alpha_ff;
      torque_in     = torque_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_drive_in  = rsp_drive_ff;
      rsp_torque_in = rsp_torque_ff;
      rsp_gain_in   = rsp_gain_ff;
      rsp_energy_in = rsp_energy_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pos_in   = req_position_x;
               vel_in   = req_velocity_x;
               ang_in   = req_joint_angle;
               state_in = ST_PH1;
               go_in    = 1'b1;
            end
         end
         ST_PH1: begin
            if (phase_end) begin
               force_in = force_p1;
               psq_in   = p2[PSQ_W+FRAC_BITS-1:FRAC_BITS];
               state_in = ST_PH2;
               go_in    = 1'b1;
            end
         end
         ST_PH2: begin
            if (phase_end) begin
               energy_in = energy_p2;
               vsq_in    = p2[VSQ_W-1:0];
               state_in  = ST_PH3;
               go_in     = 1'b1;
            end
         end
         ST_PH3: begin
            if (phase_end) begin
               alpha_in  = alpha_p3;
               torque_in = torque_p3;
               state_in  = ST_PH4;
               go_in     = 1'b1;
            end
         end
         ST_PH4: begin
            if (phase_end) begin
               force_in = force_p4;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_drive_in  = mode_ff ? {{(DATA_W - GAIN_W){1'b0}}, torque_ff} : force_ff;
               rsp_torque_in = mode_ff;
               rsp_gain_in   = alpha_ff;
               rsp_energy_in = energy_ff;
               started_in    = 1'b1;
               obs_in        = energy_ff;
               pgain_in      = alpha_ff;
               pvel_in       = vel_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ss_ff        <= SPRING_RST;
         dc_ff        <= DAMP_RST;
         thr_ff       <= THRESH_RST;
         js_ff        <= JSTIFF_RST;
         lim_ff       <= TLIMIT_RST;
         mode_ff      <= MODE_RST;
         state_ff     <= ST_IDLE;
         go_ff        <= 1'b0;
         started_ff   <= 1'b0;
         obs_ff       <= '0;
         pgain_ff     <= '0;
         pvel_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ss_ff        <= ss_in;
         dc_ff        <= dc_in;
         thr_ff       <= thr_in;
         js_ff        <= js_in;
         lim_ff       <= lim_in;
         mode_ff      <= mode_in;
         state_ff     <= state_in;
         go_ff        <= go_in;
         started_ff   <= started_in;
         obs_ff       <= obs_in;
         pgain_ff     <= pgain_in;
         pvel_ff      <= pvel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      vel_ff        <= vel_in;
      ang_ff        <= ang_in;
      force_ff      <= force_in;
      psq_ff        <= psq_in;
      energy_ff     <= energy_in;
      vsq_ff        <= vsq_in;
      alpha_ff      <= alpha_in;
      torque_ff     <= torque_in;
      rsp_drive_ff  <= rsp_drive_in;
      rsp_torque_ff <= rsp_torque_in;
      rsp_gain_ff   <= rsp_gain_in;
      rsp_energy_ff <= rsp_energy_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_value     = rsp_drive_ff;
   assign rsp_drive_is_torque = rsp_torque_ff;
   assign rsp_damping_gain    = rsp_gain_ff;
   assign rsp_energy_sum      = rsp_energy_ff;

endmodule

// ===== sim/haptic_passivity_spring_damper_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for haptic_passivity_spring_damper: a directed table and random
// servo trajectories, checked field by field against a passivity observer predictor (or against
// the typed expected values of typed rows). Depends only on hpsd_pkg and the block itself.

module haptic_passivity_spring_damper_test;
   import hpsd_pkg::*;

   localparam int     FB          = FRAC_BITS;
   localparam int     CYCLE_LIMIT = 2000000;
   localparam int     PHASE_ITEMS = 384;
   localparam int     REMAP_EVERY = 128;
   localparam longint ENERGY_TOP  = 64'sh7FFF_FFFF_FFFF;
   localparam longint ENERGY_BOT  = -ENERGY_TOP - 1;
   localparam longint unsigned GAIN_CEIL = 64'h7FFF_FFFF;

   localparam logic [1:0] ROW_REQUEST = 2'd0;
   localparam logic [1:0] ROW_TYPED   = 2'd1;
   localparam logic [1:0] ROW_WRITE   = 2'd2;

   typedef struct packed {
      data_type   drive;
      logic       is_torque;
      gain_type   gain;
      energy_type energy;
   } drive_result_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [CSR_IDX_W-1:0] reg_index;
      logic [DATA_W-1:0]    value;
      data_type             pos;
      data_type             vel;
      data_type             ang;
      drive_result_type     typed;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [DATA_W-1:0]    csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   data_type             req_position_x = '0;
   data_type             req_velocity_x = '0;
   data_type             req_joint_angle = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   data_type             rsp_drive_value;
   logic                 rsp_drive_is_torque;
   gain_type             rsp_damping_gain;
   energy_type           rsp_energy_sum;

   haptic_passivity_spring_damper uut (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_position_x      (req_position_x),
      .req_velocity_x      (req_velocity_x),
      .req_joint_angle     (req_joint_angle),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_drive_value     (rsp_drive_value),
      .rsp_drive_is_torque (rsp_drive_is_torque),
      .rsp_damping_gain    (rsp_damping_gain),
      .rsp_energy_sum      (rsp_energy_sum)
   );

   // Predictor copy of the registers and the observer state.
   longint         cfg_spring    = ((longint'(1) << FB) + 5) / 10;
   longint         cfg_damping   = -(((longint'(1) << FB) * 2 + 500) / 1000);
   longint         cfg_threshold = 0;
   longint         cfg_joint     = longint'(12000) << FB;
   longint         cfg_limit     = longint'(400) << FB;
   logic           cfg_mode      = 1'b1;
   logic           observer_started = 1'b0;
   longint         observer_energy  = 0;
   longint unsigned last_gain       = 0;
   longint         last_velocity    = 0;

   drive_result_type pending_results[$];
   stim_row_type     directed_rows[$];
   int             send_idle_pct = 0;
   int             recv_idle_pct = 0;
   int             cycle_count = 0;
   int             mismatch_count = 0;
   int             stray_count = 0;
   int             result_count = 0;
   int             request_count = 0;
   int             write_count = 0;
   int             torque_ticks = 0;
   int             damped_ticks = 0;
   int             ceiling_ticks = 0;
   int             negative_ticks = 0;
   longint         traj_pos = 0;
   longint         traj_vel = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic longint clamp32(input longint x);
      if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (x < -64'sh8000_0000) return -64'sh8000_0000;
      return x;
   endfunction

   function automatic longint clamp48(input longint x);
      if (x > ENERGY_TOP) return ENERGY_TOP;
      if (x < ENERGY_BOT) return ENERGY_BOT;
      return x;
   endfunction

   function automatic drive_result_type predict_tick(input data_type pos, input data_type vel,
                                                     input data_type ang);
      longint          p, v, a, x_force, power, energy, term, torque;
      longint unsigned pv, psq, prod, num, vsq, alpha;
      logic [127:0]    quot;
      logic            active;
      drive_result_type r;
      p = pos;
      v = vel;
      a = ang;
      active = (-p) < cfg_threshold;
      x_force = 0;
      if (active) begin
         x_force = clamp32(((-cfg_damping * v) >>> FB) + ((cfg_spring * (-p)) >>> FB));
      end
      power = (-(x_force * v)) >>> FB;
      energy = clamp48(power);
      if (observer_started) begin
         pv = (last_velocity < 0) ? -last_velocity : last_velocity;
         psq = (pv * pv) >> FB;
         if (psq != 0 && last_gain > 64'hFFFF_FFFF_FFFF_FFFF / psq) begin
            term = ENERGY_TOP;
         end else begin
            prod = (last_gain * psq) >> FB;
            term = (prod > ENERGY_TOP) ? ENERGY_TOP : longint'(prod);
         end
         energy = clamp48(observer_energy + power + term);
      end
      alpha = 0;
      if (observer_started && energy < 0) begin
         pv = (v < 0) ? -v : v;
         vsq = pv * pv;
         if (vsq == 0) begin
            alpha = GAIN_CEIL;
         end else begin
            num = -energy;
            quot = ({64'd0, num} << (2 * FB)) / {64'd0, vsq};
            alpha = (quot > GAIN_CEIL) ? GAIN_CEIL : quot[63:0];
         end
      end
      if (active) begin
         x_force = clamp32(x_force - ((longint'(alpha) * v) >>> FB));
      end
      torque = 0;
      if (a < 0) begin
         torque = (cfg_joint * (-a)) >>> FB;
      end
      if (torque > cfg_limit) begin
         torque = cfg_limit;
      end else if (torque < -cfg_limit) begin
         torque = -cfg_limit;
      end
      observer_started = 1'b1;
      observer_energy = energy;
      last_velocity = v;
      last_gain = alpha;
      r.drive = data_type'(cfg_mode ? torque : x_force);
      r.is_torque = cfg_mode;
      r.gain = gain_type'(alpha);
      r.energy = energy_type'(energy);
      return r;
   endfunction

   // Mostly the typical value, now and then an extreme or a fully random word.
   function automatic logic [31:0] spread(input logic [31:0] typical);
      case ($urandom_range(19))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3, 4: return $urandom;
         default: return typical;
      endcase
   endfunction

   task automatic add_request(input data_type pos, input data_type vel, input data_type ang);
      stim_row_type row;
      row = '0;
      row.kind = ROW_REQUEST;
      row.pos = pos;
      row.vel = vel;
      row.ang = ang;
      directed_rows.push_back(row);
   endtask

   task automatic add_typed(input data_type pos, input data_type vel, input data_type ang,
                            input data_type drive, input gain_type gain,
                            input energy_type energy);
      stim_row_type row;
      row = '0;
      row.kind = ROW_TYPED;
      row.pos = pos;
      row.vel = vel;
      row.ang = ang;
      row.typed.drive = drive;
      row.typed.is_torque = 1'b1;
      row.typed.gain = gain;
      row.typed.energy = energy;
      directed_rows.push_back(row);
   endtask

   task automatic add_write(input logic [CSR_IDX_W-1:0] reg_index, input logic [31:0] value);
      stim_row_type row;
      row = '0;
      row.kind = ROW_WRITE;
      row.reg_index = reg_index;
      row.value = value;
      directed_rows.push_back(row);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] reg_index,
                                 input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= reg_index;
      csr_wr_data <= value;
      case (reg_index)
         CSR_SPRING_STIFFNESS: cfg_spring = longint'(signed'(value));
         CSR_DAMPING_COEFF:    cfg_damping = longint'(signed'(value));
         CSR_FORCE_THRESHOLD:  cfg_threshold = longint'(signed'(value));
         CSR_JOINT_STIFFNESS:  cfg_joint = longint'({1'b0, value[30:0]});
         CSR_TORQUE_LIMIT:     cfg_limit = longint'({1'b0, value[30:0]});
         CSR_DRIVE_MODE:       cfg_mode = value[0];
         default: ;
      endcase
      write_count++;
      @(posedge clock);
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic send_request(input data_type pos, input data_type vel, input data_type ang,
                               input logic use_typed, input drive_result_type typed);
      drive_result_type predicted;
      csr_wr_en <= 1'b0;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_position_x <= pos;
      req_velocity_x <= vel;
      req_joint_angle <= ang;
      do @(posedge clock); while (req_stall);
      predicted = predict_tick(pos, vel, ang);
      request_count++;
      if (predicted.is_torque) torque_ticks++;
      if (predicted.gain != 0) damped_ticks++;
      if (predicted.gain == gain_type'(GAIN_CEIL)) ceiling_ticks++;
      if (predicted.energy < 0) negative_ticks++;
      pending_results.push_back(use_typed ? typed : predicted);
   endtask

   task automatic apply_random_settings();
      logic [31:0] spring, damping, threshold;
      spring = $urandom_range(0, 2 << FB);
      damping = $urandom_range(0, 1 << 13);
      threshold = $urandom_range(0, 200 << FB);
      if ($urandom_range(3) == 0) damping = -damping;
      if ($urandom_range(1) == 0) threshold = -threshold;
      write_register(CSR_SPRING_STIFFNESS, spread(spring));
      write_register(CSR_DAMPING_COEFF, spread(damping));
      write_register(CSR_FORCE_THRESHOLD, spread(threshold));
      write_register(CSR_JOINT_STIFFNESS, spread($urandom_range(0, 20000 << FB)));
      write_register(CSR_TORQUE_LIMIT, spread($urandom_range(0, 1000 << FB)));
      write_register(CSR_DRIVE_MODE, $urandom_range(1));
   endtask

   // Mostly a continuous servo trajectory so the observer builds up history; the rest is noise.
   task automatic next_servo_tick(output data_type pos, output data_type vel,
                                  output data_type ang);
      longint ang_span;
      ang_span = longint'(2) << FB;
      if ($urandom_range(99) < 75) begin
         traj_vel = traj_vel + longint'($urandom_range(0, 8 << FB)) - (longint'(4) << FB);
         if ($urandom_range(19) == 0) traj_vel = 0;
         if (traj_vel > (longint'(500) << FB) || traj_vel < -(longint'(500) << FB)) begin
            traj_vel = -(traj_vel >>> 1);
         end
         traj_pos = traj_pos + (traj_vel >>> 4);
         if (traj_pos > (longint'(300) << FB) || traj_pos < -(longint'(300) << FB)) begin
            traj_vel = -traj_vel;
            traj_pos = traj_pos >>> 1;
         end
         pos = data_type'(traj_pos);
         vel = data_type'(traj_vel);
         ang = data_type'(longint'($urandom_range(0, 2 * ang_span)) - ang_span);
      end else begin
         pos = spread($urandom);
         vel = spread($urandom_range(0, 2000 << FB) - (1000 << FB));
         ang = spread($urandom);
      end
   endtask

   always @(posedge clock) begin : result_check
      drive_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (pending_results.size() == 0) begin
            stray_count++;
            if (mismatch_count + stray_count <= 10) begin
               $display("Unexpected result: drive %0d torque %0b gain %0d energy %0d",
                        rsp_drive_value, rsp_drive_is_torque, rsp_damping_gain,
                        rsp_energy_sum);
            end
         end else begin
            want = pending_results.pop_front();
            if (rsp_drive_value !== want.drive || rsp_drive_is_torque !== want.is_torque ||
                rsp_damping_gain !== want.gain || rsp_energy_sum !== want.energy) begin
               mismatch_count++;
               if (mismatch_count + stray_count <= 10) begin
                  $display("Mismatch on result %0d: expected drive %0d torque %0b gain %0d",
                           result_count, want.drive, want.is_torque, want.gain);
                  $display("   energy %0d, got drive %0d torque %0b gain %0d energy %0d",
                           want.energy, rsp_drive_value, rsp_drive_is_torque,
                           rsp_damping_gain, rsp_energy_sum);
               end
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results outstanding.",
                  cycle_count, pending_results.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      data_type     pos, vel, ang;
      int           fail_count;

      add_typed(0, 0, 0, 0, 0, 0);
      add_typed(0, 0, 32'shFFFF_0000, 32'sh0190_0000, 0, 0);
      add_typed(0, 0, 32'sh8000_0000, 32'sh0190_0000, 0, 0);
      add_typed(0, 0, 32'sh7FFF_FFFF, 0, 0, 0);
      add_write(CSR_DRIVE_MODE, 32'd0);
      add_write(CSR_DAMPING_COEFF, 32'h0000_0CCD);
      add_request(32'sh000A_0000, 32'sh0005_0000, 0);
      add_request(32'sh000A_0000, 32'shFFFB_0000, 0);
      add_request(32'sh0014_0000, 32'shFFF0_0000, 0);
      add_request(32'sh000A_0000, 0, 0);
      add_request(32'sh7FFF_FFFF, 32'sh8000_0000, 0);
      add_request(32'sh8000_0000, 32'sh7FFF_FFFF, 0);
      add_request(32'sh0000_0001, 32'sh0000_0001, 0);
      add_write(CSR_SPRING_STIFFNESS, 32'h7FFF_FFFF);
      add_write(CSR_DAMPING_COEFF, 32'h8000_0000);
      add_write(CSR_FORCE_THRESHOLD, 32'h7FFF_FFFF);
      add_request(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0);
      add_request(32'shFF9C_0000, 32'sh8000_0000, 32'shFFFF_FFFF);
      add_request(0, 32'shFFFF_FFFF, 32'sh8000_0000);
      add_request(32'sh0003_0000, 0, 0);
      add_write(CSR_FORCE_THRESHOLD, 32'h8000_0000);
      add_write(CSR_JOINT_STIFFNESS, 32'h7FFF_FFFF);
      add_write(CSR_TORQUE_LIMIT, 32'h7FFF_FFFF);
      add_write(CSR_DRIVE_MODE, 32'd1);
      add_request(32'sh0005_0000, 32'sh0003_0000, 32'sh8000_0000);
      add_request(0, 0, 32'shFFFF_FFFF);
      add_write(CSR_TORQUE_LIMIT, 32'h0000_0000);
      add_request(0, 32'sh0002_0000, 32'sh8000_0000);
      add_write(CSR_SPRING_STIFFNESS, 32'h8000_0000);
      add_write(CSR_DAMPING_COEFF, 32'h7FFF_FFFF);
      add_write(CSR_FORCE_THRESHOLD, 32'h0000_0000);
      add_write(CSR_TORQUE_LIMIT, 32'h0190_0000);
      add_write(CSR_DRIVE_MODE, 32'd0);
      add_request(32'sh8000_0000, 32'sh8000_0000, 0);
      add_request(32'sh0001_0000, 32'sh0002_0000, 32'sh7FFF_FFFF);
      add_request(32'sh0001_0000, 32'shFFFE_0000, 32'shFFFF_0000);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < directed_rows.size(); i++) begin
         row = directed_rows[i];
         if (row.kind == ROW_WRITE) begin
            wait_until_idle();
            write_register(row.reg_index, row.value);
         end else begin
            send_request(row.pos, row.vel, row.ang, row.kind == ROW_TYPED, row.typed);
         end
      end

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 36;
               recv_idle_pct = 82;
            end
            1: begin
               send_idle_pct = 82;
               recv_idle_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % REMAP_EVERY == 0) begin
               wait_until_idle();
               apply_random_settings();
            end
            next_servo_tick(pos, vel, ang);
            send_request(pos, vel, ang, 1'b0, '0);
         end
      end

      wait_until_idle();
      repeat (300) @(posedge clock);
      fail_count = mismatch_count + stray_count + pending_results.size();
      $display("Ran %0d requests (%0d in torque mode) across %0d register writes.",
               request_count, torque_ticks, write_count);
      $display("Damping engaged on %0d ticks, %0d at the gain ceiling; %0d ended below zero.",
               damped_ticks, ceiling_ticks, negative_ticks);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/hpsd_pkg.sv
sv/hpsd_mul.sv
sv/hpsd_div.sv
sv/haptic_passivity_spring_damper.sv
sim/haptic_passivity_spring_damper_test.sv
